[rtl/bwb_pkg.sv]
package bwb_pkg;

   // message store geometry
   localparam int MAX_WORDS   = 32;
   localparam int MAX_RESULTS = 31;
   localparam int IDX_W       = $clog2(MAX_WORDS);
   localparam int WCNT_W      = 6;
   localparam int CNT_W       = 5;

   // input command codes
   typedef enum logic [1:0] {
      CMD_MSG   = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_ACK   = 2'd2
   } cmd_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_MEM_WRITE = 3'd0,
      KIND_READ_BUF  = 3'd1,
      KIND_SLOT_A    = 3'd2,
      KIND_SLOT_B    = 3'd3,
      KIND_PASSWORD  = 3'd4,
      KIND_RESET     = 3'd5
   } kind_type;

   // mode command words
   localparam logic [15:0] WORD_BOOT      = 16'hB105;
   localparam logic [15:0] WORD_RESET_REQ = 16'hB007;
   localparam logic [15:0] WORD_EAV_OFF   = 16'hEA40;
   localparam logic [15:0] WORD_EAV_ON    = 16'hEA41;
   localparam logic [15:0] PW_EAV         = 16'hEA4E;

   // unlock message
   localparam logic [15:0] UNLOCK_ADDR = 16'h10C0;
   localparam logic [7:0]  UNLOCK_B2   = 8'hAB;
   localparam logic [7:0]  UNLOCK_B3   = 8'h1E;
   localparam logic [7:0]  UNLOCK_CHK  =
      8'(UNLOCK_ADDR[15:8] + UNLOCK_ADDR[7:0] + UNLOCK_B2 + UNLOCK_B3);

   // reply lengths
   localparam logic [2:0] LEN_BUF  = 3'd5;
   localparam logic [2:0] LEN_SLOT = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_ACK,
      ST_UNLOCK,
      ST_PASSWORD,
      ST_CMD_REPLY,
      ST_RESET_REQ
   } state_type;

   // message store port
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [15:0]      wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
   } mem_req_type;

endpackage

[rtl/bwb_ifs.sv]
// request channel into the handler
interface bwb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] data_word;
   logic        start_of_message;

   modport source (output valid, output command, output data_word,
                   output start_of_message, input ready);
   modport sink   (input valid, input command, input data_word,
                   input start_of_message, output ready);
endinterface

// result channel out of the handler
interface bwb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] mem_address;
   logic [15:0] mem_data;
   logic [4:0]  reply_offset;
   logic [2:0]  reply_length;
   logic [7:0]  reply_byte0;
   logic [7:0]  reply_byte1;
   logic [7:0]  reply_byte2;
   logic [7:0]  reply_byte3;
   logic [7:0]  reply_byte4;
   logic        last;

   modport source (output valid, output kind, output mem_address, output mem_data,
                   output reply_offset, output reply_length, output reply_byte0,
                   output reply_byte1, output reply_byte2, output reply_byte3,
                   output reply_byte4, output last, input ready);
   modport sink   (input valid, input kind, input mem_address, input mem_data,
                   input reply_offset, input reply_length, input reply_byte0,
                   input reply_byte1, input reply_byte2, input reply_byte3,
                   input reply_byte4, input last, output ready);
endinterface

[rtl/bwb_store.sv]
module bwb_store (
   input  logic                clock,
   input  bwb_pkg::mem_req_type mem_req,
   output logic [15:0]         rd_data
);
   import bwb_pkg::*;

   logic [15:0] mem [MAX_WORDS];
   logic [15:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_idx] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bwb_ctrl.sv]
module bwb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   bwb_req_if.sink              req_ch,
   bwb_rsp_if.source            rsp_ch,
   output bwb_pkg::mem_req_type mem_req,
   input  logic [15:0]          rd_data
);
   import bwb_pkg::*;

   // control state
   state_type          state_ff, state_in;
   logic [WCNT_W-1:0]  wr_cnt_ff, wr_cnt_in;
   logic               eav_ff, eav_in;
   logic               slot_a_ff, slot_a_in;
   logic               slot_b_ff, slot_b_in;

   // payload registers
   logic [15:0]        hdr_ff, hdr_in;
   logic [15:0]        addr_ff, addr_in;
   logic [15:0]        wa_ff, wa_in;
   logic [7:0]         sum_ff, sum_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [15:0]        cmd_ff, cmd_in;

   logic [CNT_W-1:0]   cnt;
   logic [WCNT_W-1:0]  wr_next;
   logic [WCNT_W-1:0]  done_cnt;
   logic [WCNT_W-1:0]  rd_pos;
   logic [CNT_W-1:0]   idx_next;
   logic [7:0]         sum_next;
   logic               over;
   logic [15:0]        pw_value;

   assign cnt      = hdr_ff[12:8];
   assign wr_next  = (wr_cnt_ff != '1) ? wr_cnt_ff + WCNT_W'(1) : wr_cnt_ff;
   assign done_cnt = WCNT_W'(cnt) + WCNT_W'(2);
   assign rd_pos   = WCNT_W'(idx_ff) + WCNT_W'(2);
   assign idx_next = idx_ff + CNT_W'(1);
   assign sum_next = sum_ff + req_ch.data_word[15:8] + req_ch.data_word[7:0];
   assign over     = (int'(cnt) + 2 > MAX_WORDS) || (int'(cnt) + 1 > MAX_RESULTS);

   // password that goes with the stored mode command
   always_comb begin
      unique case (cmd_ff)
         WORD_RESET_REQ: pw_value = WORD_RESET_REQ;
         WORD_EAV_ON:    pw_value = PW_EAV;
         default:        pw_value = WORD_BOOT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wr_cnt_ff <= '0;
         eav_ff    <= 1'b0;
         slot_a_ff <= 1'b0;
         slot_b_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_cnt_ff <= wr_cnt_in;
         eav_ff    <= eav_in;
         slot_a_ff <= slot_a_in;
         slot_b_ff <= slot_b_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      addr_ff <= addr_in;
      wa_ff   <= wa_in;
      sum_ff  <= sum_in;
      idx_ff  <= idx_in;
      cmd_ff  <= cmd_in;
   end

   // sequencer: next state, store port and result fields
   always_comb begin
      state_in  = state_ff;
      wr_cnt_in = wr_cnt_ff;
      eav_in    = eav_ff;
      slot_a_in = slot_a_ff;
      slot_b_in = slot_b_ff;
      hdr_in    = hdr_ff;
      addr_in   = addr_ff;
      wa_in     = wa_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;

      mem_req         = '0;
      mem_req.wr_data = req_ch.data_word;

      req_ch.ready        = (state_ff == ST_IDLE);
      rsp_ch.valid        = 1'b0;
      rsp_ch.kind         = KIND_MEM_WRITE;
      rsp_ch.mem_address  = '0;
      rsp_ch.mem_data     = '0;
      rsp_ch.reply_offset = '0;
      rsp_ch.reply_length = '0;
      rsp_ch.reply_byte0  = '0;
      rsp_ch.reply_byte1  = '0;
      rsp_ch.reply_byte2  = '0;
      rsp_ch.reply_byte3  = '0;
      rsp_ch.reply_byte4  = '0;
      rsp_ch.last         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               unique case (cmd_type'(req_ch.command))
                  CMD_MSG: begin
                     if (req_ch.start_of_message) begin
                        // header opens a new message
                        hdr_in         = req_ch.data_word;
                        wr_cnt_in      = WCNT_W'(1);
                        sum_in         = '0;
                        mem_req.wr_en  = 1'b1;
                        mem_req.wr_idx = '0;
                     end else if (wr_cnt_ff != '0) begin
                        if (int'(wr_cnt_ff) < MAX_WORDS) begin
                           mem_req.wr_en  = 1'b1;
                           mem_req.wr_idx = wr_cnt_ff[IDX_W-1:0];
                        end
                        if (wr_cnt_ff == WCNT_W'(1)) begin
                           addr_in = req_ch.data_word;
                        end
                        wr_cnt_in = wr_next;
                        sum_in    = sum_next;
                        // last word of the message: check and launch
                        if (wr_next == done_cnt) begin
                           wr_cnt_in = '0;
                           wa_in     = addr_ff;
                           idx_in    = '0;
                           if (sum_next == hdr_ff[7:0]) begin
                              if (cnt == '0) begin
                                 state_in = ST_UNLOCK;
                              end else if (!over) begin
                                 state_in = ST_READ;
                              end
                           end
                        end
                     end
                  end
                  CMD_WRITE: begin
                     cmd_in = req_ch.data_word;
                     if (req_ch.data_word == WORD_BOOT ||
                         req_ch.data_word == WORD_EAV_OFF) begin
                        eav_in   = 1'b0;
                        state_in = ST_PASSWORD;
                     end else if (req_ch.data_word == WORD_EAV_ON) begin
                        eav_in   = 1'b1;
                        state_in = ST_PASSWORD;
                     end else if (req_ch.data_word == WORD_RESET_REQ) begin
                        state_in = ST_PASSWORD;
                     end
                  end
                  CMD_ACK: begin
                     if (eav_ff) begin
                        slot_a_in = 1'b0;
                        slot_b_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            mem_req.rd_en  = 1'b1;
            mem_req.rd_idx = rd_pos[IDX_W-1:0];
            state_in       = ST_WRITE;
         end
         ST_WRITE: begin
            rsp_ch.valid       = 1'b1;
            rsp_ch.kind        = KIND_MEM_WRITE;
            rsp_ch.mem_address = wa_ff;
            rsp_ch.mem_data    = rd_data;
            if (rsp_ch.ready) begin
               wa_in = wa_ff + 16'd2;
               if (idx_next == cnt) begin
                  state_in = ST_ACK;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_READ;
               end
            end
         end
         ST_ACK: begin
            rsp_ch.valid       = 1'b1;
            rsp_ch.last        = 1'b1;
            rsp_ch.reply_byte0 = 8'(cnt);
            rsp_ch.reply_byte1 = hdr_ff[7:0];
            rsp_ch.reply_byte2 = addr_ff[15:8];
            rsp_ch.reply_byte3 = addr_ff[7:0];
            if (!eav_ff) begin
               rsp_ch.kind         = KIND_READ_BUF;
               rsp_ch.reply_offset = {hdr_ff[15:13], 2'b00};
               rsp_ch.reply_length = LEN_BUF;
            end else if (slot_a_ff && !slot_b_ff) begin
               rsp_ch.kind         = KIND_SLOT_B;
               rsp_ch.reply_length = LEN_SLOT;
            end else begin
               rsp_ch.kind         = KIND_SLOT_A;
               rsp_ch.reply_length = LEN_SLOT;
            end
            if (rsp_ch.ready) begin
               if (eav_ff && slot_a_ff && !slot_b_ff) begin
                  slot_b_in = 1'b1;
               end else if (eav_ff) begin
                  slot_a_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_UNLOCK: begin
            rsp_ch.valid        = 1'b1;
            rsp_ch.last         = 1'b1;
            rsp_ch.kind         = KIND_READ_BUF;
            rsp_ch.reply_length = LEN_BUF;
            rsp_ch.reply_byte1  = (addr_ff == UNLOCK_ADDR) ? UNLOCK_CHK : hdr_ff[7:0];
            rsp_ch.reply_byte2  = UNLOCK_B2;
            rsp_ch.reply_byte3  = UNLOCK_B3;
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_PASSWORD: begin
            rsp_ch.valid    = 1'b1;
            rsp_ch.kind     = KIND_PASSWORD;
            rsp_ch.mem_data = pw_value;
            if (rsp_ch.ready) begin
               state_in = (cmd_ff == WORD_RESET_REQ) ? ST_RESET_REQ : ST_CMD_REPLY;
            end
         end
         ST_CMD_REPLY: begin
            rsp_ch.valid        = 1'b1;
            rsp_ch.last         = 1'b1;
            rsp_ch.kind         = KIND_READ_BUF;
            rsp_ch.reply_length = (cmd_ff == WORD_BOOT) ? LEN_BUF : LEN_SLOT;
            rsp_ch.reply_byte0  = cmd_ff[15:8];
            rsp_ch.reply_byte1  = cmd_ff[7:0];
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESET_REQ: begin
            rsp_ch.valid = 1'b1;
            rsp_ch.last  = 1'b1;
            rsp_ch.kind  = KIND_RESET;
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/block_write_bootloader_handler_unit.sv]
// Block-write bootloader handler.
// req_ch carries one request per handshake: a message word (command 0, with
// start_of_message on the header), a mode command word (command 1) or an
// acknowledge event (command 2). rsp_ch carries the results: memory writes,
// a reply for the read buffer or an ID slot, a password write, a reset request.
// The final result of a request has last set; a request may cause none.
// req_ch.ready is high only while no result is pending, so requests are taken
// one per cycle while idle. The word that completes a good message with data
// words starts a pass over the message store: each data word is read from the
// single read port of the store in ST_READ, then given as a write result in
// ST_WRITE, and an acknowledgement result in ST_ACK closes the pass. A good
// message with no data words gives one unlock reply instead. A mode command
// gives two results. Bad sums and oversized messages give nothing and the
// block stays ready.
// A stalled receiver holds the current result steady until it is taken.
// Synchronous reset closes any open message, clears the eavesdrop flag and
// both ID slots; store contents are not cleared and need no clearing pass.
module block_write_bootloader_handler_unit (
   input logic       clock,
   input logic       reset,
   bwb_req_if.sink   req_ch,
   bwb_rsp_if.source rsp_ch
);
   import bwb_pkg::*;

   mem_req_type mem_req;
   logic [15:0] rd_data;

   // sequencer with address and sum adders
   bwb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // message word store
   bwb_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

[rtl/bwb_checker.sv]
module bwb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [15:0] rsp_mem_address,
   input logic [15:0] rsp_mem_data,
   input logic        rsp_last
);
   import bwb_pkg::*;

   // a stalled result holds
   hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_mem_address) && $stable(rsp_mem_data) && $stable(rsp_last))
      else $error("stalled result changed");

   // no request taken while a result is pending
   busy_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   // block returns to ready after the final result
   idle_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not ready after last result");

   // memory and password writes are always followed by another result
   tail_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_MEM_WRITE || rsp_kind == KIND_PASSWORD)
         |-> !rsp_last)
      else $error("write result marked last");

endmodule

bind block_write_bootloader_handler_unit bwb_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_kind        (rsp_ch.kind),
   .rsp_mem_address (rsp_ch.mem_address),
   .rsp_mem_data    (rsp_ch.mem_data),
   .rsp_last        (rsp_ch.last)
);
